// ----- hw/rtl/alc_pkg.sv -----
package alc_pkg;

    localparam int STATUS_W   = 8;
    localparam int COUNT_W    = 16;
    localparam int LUX_W      = 26;
    localparam int RANGE_W    = 3;
    localparam int ITIME_W    = 3;
    localparam int GAIN_CODE_W = 3;
    localparam int GAIN_W     = 7;
    localparam int TSCALE_W   = 9;
    localparam int DIVISOR_W  = GAIN_W + TSCALE_W;
    localparam int RAW_W      = 32;
    localparam int COEF_W     = 16;
    localparam int CAP_W      = 23;
    localparam int LIMIT_W    = 27;
    localparam int SUM_W      = COUNT_W + 1;
    localparam int STEP_CNT_W = $clog2(RAW_W);

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_LUX_RANGE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPOSURE  = 2'd1;

    localparam logic [RANGE_W-1:0] LUX_RANGE_RESET = 3'd3;
    localparam logic [ITIME_W-1:0] ITIME_RESET     = 3'd2;

    localparam int ST_NEW_BIT     = 2;
    localparam int ST_INVALID_BIT = 7;
    localparam int ST_GAIN_LSB    = 4;

    // ratio thresholds in thousandths
    localparam logic [LIMIT_W-1:0] RATIO_SCALE = 27'd1000;
    localparam logic [LIMIT_W-1:0] RATIO_LOW   = 27'd450;
    localparam logic [LIMIT_W-1:0] RATIO_MID   = 27'd640;
    localparam logic [LIMIT_W-1:0] RATIO_HIGH  = 27'd850;

    localparam logic [COEF_W-1:0] COEF_LOW_VIS  = 16'd17743;
    localparam logic [COEF_W-1:0] COEF_LOW_IR   = 16'd11059;
    localparam logic [COEF_W-1:0] COEF_MID_VIS  = 16'd42785;
    localparam logic [COEF_W-1:0] COEF_MID_IR   = 16'd19548;
    localparam logic [COEF_W-1:0] COEF_HIGH_VIS = 16'd5926;
    localparam logic [COEF_W-1:0] COEF_HIGH_IR  = 16'd1185;

    typedef enum logic [1:0] {
        SEG_LOW,
        SEG_MID,
        SEG_HIGH,
        SEG_ZERO
    } seg_t;

    typedef struct packed {
        logic load;
        logic seg;
        logic mul;
        logic raw;
        logic div_step;
        logic emit;
        logic emit_zero;
    } alc_cmd_t;

    typedef struct packed {
        logic out_free;
    } alc_stat_t;

    function automatic logic [GAIN_W-1:0] gain_of(input logic [GAIN_CODE_W-1:0] code);
        logic [GAIN_W-1:0] g;
        unique case (code)
            3'd1:    g = 7'd2;
            3'd2:    g = 7'd4;
            3'd3:    g = 7'd8;
            3'd6:    g = 7'd48;
            3'd7:    g = 7'd96;
            default: g = 7'd1;
        endcase
        return g;
    endfunction

    // (code + 1) * 50
    function automatic logic [TSCALE_W-1:0] time_scale(input logic [ITIME_W-1:0] code);
        logic [TSCALE_W-1:0] t;
        unique case (code)
            3'd0:    t = 9'd50;
            3'd1:    t = 9'd100;
            3'd2:    t = 9'd150;
            3'd3:    t = 9'd200;
            3'd4:    t = 9'd250;
            3'd5:    t = 9'd300;
            3'd6:    t = 9'd350;
            default: t = 9'd400;
        endcase
        return t;
    endfunction

    function automatic logic [CAP_W-1:0] cap_of(input logic [RANGE_W-1:0] range);
        logic [CAP_W-1:0] c;
        unique case (range)
            3'd0:    c = 23'd6400001;
            3'd1:    c = 23'd3200001;
            3'd2:    c = 23'd1600001;
            3'd3:    c = 23'd800001;
            3'd4:    c = 23'd130001;
            3'd5:    c = 23'd60001;
            default: c = '1;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/alc_ctrl.sv -----
module alc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               new_data,
    input  logic               invalid,
    input  logic               cfg_we,
    input  alc_pkg::alc_stat_t stat,
    output logic               in_ready,
    output alc_pkg::alc_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEG,
        ST_MUL,
        ST_RAW,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t                           state_reg, state_next;
    logic                             discard_reg, discard_next;
    logic                             zero_reg, zero_next;
    logic [alc_pkg::STEP_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                             accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next   = state_reg;
        discard_next = discard_reg;
        zero_next    = zero_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && new_data)
                begin
                    if (invalid)
                    begin
                        zero_next  = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else if (discard_reg)
                    begin
                        // drop the first valid reading
                        discard_next = 1'b0;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        zero_next  = 1'b0;
                        state_next = ST_SEG;
                    end
                end
            end
            ST_SEG:
            begin
                cmd.seg    = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_RAW;
            end
            ST_RAW:
            begin
                cmd.raw    = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_zero = zero_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_we)
        begin
            discard_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            discard_reg <= 1'b1;
            zero_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            discard_reg <= discard_next;
            zero_reg    <= zero_next;
            cnt_reg     <= cnt_next;
        end
    end

endmodule

// ----- hw/rtl/alc_datapath.sv -----
module alc_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  alc_pkg::alc_cmd_t               cmd,
    output alc_pkg::alc_stat_t              stat,
    input  logic                            cfg_we,
    input  logic [alc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [alc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [alc_pkg::GAIN_CODE_W-1:0] gain_code,
    input  logic [alc_pkg::COUNT_W-1:0]     visible_count,
    input  logic [alc_pkg::COUNT_W-1:0]     infrared_count,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [alc_pkg::LUX_W-1:0]       lux_centi
);

    logic [alc_pkg::RANGE_W-1:0]     range_reg;
    logic [alc_pkg::ITIME_W-1:0]     itime_reg;
    logic [alc_pkg::COUNT_W-1:0]     vis_reg, ir_reg;
    logic [alc_pkg::GAIN_CODE_W-1:0] gcode_reg;
    alc_pkg::seg_t                   seg_reg, seg_next;
    logic [alc_pkg::RAW_W-1:0]       pos_reg, neg_reg;
    logic [alc_pkg::DIVISOR_W-1:0]   divisor_reg;
    logic [alc_pkg::RAW_W-1:0]       quo_reg;
    logic [alc_pkg::COUNT_W-1:0]     rem_reg;
    logic                            out_valid_reg, out_valid_next;
    logic [alc_pkg::LUX_W-1:0]       lux_reg, lux_next;

    logic [alc_pkg::SUM_W-1:0]       sum;
    logic [alc_pkg::LIMIT_W-1:0]     ir_k, lim_lo, lim_mid, lim_hi;
    logic [alc_pkg::COEF_W-1:0]      coef_vis, coef_ir;
    logic [alc_pkg::RAW_W:0]         raw_add;
    logic [alc_pkg::RAW_W-1:0]       raw;
    logic [alc_pkg::COUNT_W:0]       trial;
    logic                            ge;
    logic [alc_pkg::CAP_W-1:0]       cap;
    logic [alc_pkg::RAW_W-1:0]       capped;

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign lux_centi     = lux_reg;

    // ratio band: floor(1000*ir/sum) < k  <=>  1000*ir < k*sum
    always_comb
    begin
        sum     = alc_pkg::SUM_W'(vis_reg) + alc_pkg::SUM_W'(ir_reg);
        ir_k    = alc_pkg::LIMIT_W'(ir_reg) * alc_pkg::RATIO_SCALE;
        lim_lo  = alc_pkg::LIMIT_W'(sum) * alc_pkg::RATIO_LOW;
        lim_mid = alc_pkg::LIMIT_W'(sum) * alc_pkg::RATIO_MID;
        lim_hi  = alc_pkg::LIMIT_W'(sum) * alc_pkg::RATIO_HIGH;
        priority if (ir_k < lim_lo)
            seg_next = alc_pkg::SEG_LOW;
        else if (ir_k < lim_mid)
            seg_next = alc_pkg::SEG_MID;
        else if (ir_k < lim_hi)
            seg_next = alc_pkg::SEG_HIGH;
        else
            seg_next = alc_pkg::SEG_ZERO;
    end

    always_comb
    begin
        unique case (seg_reg)
            alc_pkg::SEG_LOW:
            begin
                coef_vis = alc_pkg::COEF_LOW_VIS;
                coef_ir  = alc_pkg::COEF_LOW_IR;
            end
            alc_pkg::SEG_MID:
            begin
                coef_vis = alc_pkg::COEF_MID_VIS;
                coef_ir  = alc_pkg::COEF_MID_IR;
            end
            alc_pkg::SEG_HIGH:
            begin
                coef_vis = alc_pkg::COEF_HIGH_VIS;
                coef_ir  = alc_pkg::COEF_HIGH_IR;
            end
            default:
            begin
                coef_vis = '0;
                coef_ir  = '0;
            end
        endcase
    end

    always_comb
    begin
        raw_add = (alc_pkg::RAW_W + 1)'(pos_reg) + (alc_pkg::RAW_W + 1)'(neg_reg);
        if (seg_reg == alc_pkg::SEG_MID)
            raw = (pos_reg > neg_reg) ? (pos_reg - neg_reg) : '0;
        else
            raw = raw_add[alc_pkg::RAW_W-1:0];
    end

    // one quotient bit per step, restoring
    always_comb
    begin
        trial = {rem_reg, quo_reg[alc_pkg::RAW_W-1]};
        ge    = (trial >= (alc_pkg::COUNT_W + 1)'(divisor_reg));
    end

    always_comb
    begin
        cap    = alc_pkg::cap_of(range_reg);
        capped = quo_reg;
        if ((range_reg < 3'd6) && (quo_reg > alc_pkg::RAW_W'(cap)))
            capped = alc_pkg::RAW_W'(cap);
        if (capped == '0)
            capped = alc_pkg::RAW_W'(1);
        lux_next = cmd.emit_zero ? '0 : capped[alc_pkg::LUX_W-1:0];
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg     <= alc_pkg::LUX_RANGE_RESET;
            itime_reg     <= alc_pkg::ITIME_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == alc_pkg::REG_LUX_RANGE))
                range_reg <= cfg_data[alc_pkg::RANGE_W-1:0];
            if (cfg_we && (cfg_index == alc_pkg::REG_EXPOSURE))
                itime_reg <= cfg_data[alc_pkg::ITIME_W-1:0];
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            vis_reg   <= visible_count;
            ir_reg    <= infrared_count;
            gcode_reg <= gain_code;
        end
        if (cmd.seg)
            seg_reg <= seg_next;
        if (cmd.mul)
        begin
            pos_reg     <= alc_pkg::RAW_W'(vis_reg) * alc_pkg::RAW_W'(coef_vis);
            neg_reg     <= alc_pkg::RAW_W'(ir_reg) * alc_pkg::RAW_W'(coef_ir);
            divisor_reg <= alc_pkg::DIVISOR_W'(alc_pkg::gain_of(gcode_reg))
                         * alc_pkg::DIVISOR_W'(alc_pkg::time_scale(itime_reg));
        end
        if (cmd.raw)
        begin
            quo_reg <= raw;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[alc_pkg::RAW_W-2:0], ge};
            rem_reg <= ge ? alc_pkg::COUNT_W'(trial - (alc_pkg::COUNT_W + 1)'(divisor_reg))
                          : trial[alc_pkg::COUNT_W-1:0];
        end
        if (cmd.emit)
            lux_reg <= lux_next;
    end

endmodule

// ----- hw/rtl/ambient_light_lux_calc_top.sv -----
// Channel   Dir  Handshake          Payload
// s_axis    in   s_tvalid/s_tready  s_tdata: status, visible_count, infrared_count
// m_axis    out  m_tvalid/m_tready  m_tdata: lux_centi
// cfg       in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A poll with no new-data flag or a discarded reading leaves the block idle. A computed
// result goes through the ratio band, the two channel products and the divisor, the raw
// value, then the one-bit-per-cycle restoring divider, and then the emit state.
// An invalid reading goes straight to the emit state and gives 0.
// Reset clears control and loads lux_range 3, exposure code 2.
// s_tready drops while an item is in work; the output register lets it return
// while a result waits. cfg_ready is always high.
module ambient_light_lux_calc_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [7:0] status, [23:8] visible_count, [39:24] infrared_count
    input  logic [alc_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [25:0] lux_centi, [31:26] zero
    output logic [alc_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [alc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [alc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    alc_pkg::alc_cmd_t            cmd;
    alc_pkg::alc_stat_t           stat;
    logic                         cfg_we;
    logic                         cfg_known;
    logic [alc_pkg::LUX_W-1:0]    lux_centi;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign cfg_known = cfg_we && ((cfg_index == alc_pkg::REG_LUX_RANGE) ||
                                  (cfg_index == alc_pkg::REG_EXPOSURE));
    assign m_tdata   = alc_pkg::OUT_TDATA_W'(lux_centi);

    alc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .new_data (s_tdata[alc_pkg::ST_NEW_BIT]),
        .invalid  (s_tdata[alc_pkg::ST_INVALID_BIT]),
        .cfg_we   (cfg_known),
        .stat     (stat),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    alc_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .gain_code      (s_tdata[alc_pkg::ST_GAIN_LSB +: alc_pkg::GAIN_CODE_W]),
        .visible_count  (s_tdata[alc_pkg::STATUS_W +: alc_pkg::COUNT_W]),
        .infrared_count (s_tdata[alc_pkg::STATUS_W + alc_pkg::COUNT_W +: alc_pkg::COUNT_W]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .lux_centi      (lux_centi)
    );

endmodule

// ----- hw/rtl/alc_checker.sv -----
module alc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [alc_pkg::IN_TDATA_W-1:0]  s_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [alc_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[alc_pkg::OUT_TDATA_W-1:alc_pkg::LUX_W] == '0))
        else $error("result padding not zero");

    // a poll without new data leaves the block ready
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tdata[alc_pkg::ST_NEW_BIT] |=> s_tready)
        else $error("block busy after empty poll");

    // an invalid reading always goes on to emit a result
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tdata[alc_pkg::ST_NEW_BIT]
            && s_tdata[alc_pkg::ST_INVALID_BIT] |=> !s_tready)
        else $error("invalid reading did not start a result");

endmodule

bind ambient_light_lux_calc_top alc_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- dv/ambient_light_lux_calc_top_tb.sv -----
module ambient_light_lux_calc_top_tb;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 4;
    localparam int SETTLE_CYCLES   = 40;
    localparam int QUIET_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASES          = 15;
    localparam int PHASE_ITEMS     = 75;
    localparam int MAX_PRINTED     = 100;
    localparam int LUX_W           = alc_pkg::LUX_W;

    // indexes past the register list; writes there must change nothing
    localparam logic [alc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [alc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    // channel ratio band edges, in thousandths
    localparam int unsigned LOW_BAND_END  = 450;
    localparam int unsigned MID_BAND_END  = 640;
    localparam int unsigned HIGH_BAND_END = 850;

    typedef enum logic [2:0] {
        GAIN_1,
        GAIN_2,
        GAIN_4,
        GAIN_8,
        GAIN_RSVD4,
        GAIN_RSVD5,
        GAIN_48,
        GAIN_96
    } gain_code_e;

    typedef enum logic [2:0] {
        RANGE_64K,
        RANGE_32K,
        RANGE_16K,
        RANGE_8K,
        RANGE_1300,
        RANGE_600,
        RANGE_OPEN,
        RANGE_OPEN_ALT
    } range_code_e;

    typedef logic [alc_pkg::IN_TDATA_W-1:0] poll_t;

    class lux_predictor;
        logic [2:0]       range_code;
        logic [2:0]       itime_code;
        bit               discard_pending;
        logic [LUX_W-1:0] pending_lux[$];
        int               errors;

        function new();
            range_code      = alc_pkg::LUX_RANGE_RESET;
            itime_code      = alc_pkg::ITIME_RESET;
            discard_pending = 1'b1;
            errors          = 0;
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED)
                $display("[%0t] lux check: %s", $time, msg);
            errors++;
        endtask

        function int pending();
            return pending_lux.size();
        endfunction

        function longint unsigned gain_x(logic [2:0] code);
            longint unsigned g;
            case (gain_code_e'(code))
                GAIN_2:  g = 2;
                GAIN_4:  g = 4;
                GAIN_8:  g = 8;
                GAIN_48: g = 48;
                GAIN_96: g = 96;
                default: g = 1;
            endcase
            return g;
        endfunction

        function longint unsigned cap_for(logic [2:0] code);
            longint unsigned c;
            case (range_code_e'(code))
                RANGE_64K:  c = 6400001;
                RANGE_32K:  c = 3200001;
                RANGE_16K:  c = 1600001;
                RANGE_8K:   c = 800001;
                RANGE_1300: c = 130001;
                RANGE_600:  c = 60001;
                default:    c = 64'hFFFF_FFFF_FFFF_FFFF;
            endcase
            return c;
        endfunction

        function logic [LUX_W-1:0] lux_of(logic [15:0] vis, logic [15:0] ir, logic [2:0] gcode);
            logic [16:0]     total;
            longint unsigned ratio;
            longint unsigned raw;
            longint unsigned pos;
            longint unsigned neg;
            longint unsigned divisor;
            longint unsigned cap;
            total = {1'b0, vis} + {1'b0, ir};
            ratio = (total == 0) ? 64'd0 : (64'(ir) * 1000) / total;
            if (ratio < LOW_BAND_END)
                raw = 64'(vis) * 17743 + 64'(ir) * 11059;
            else if (ratio < MID_BAND_END)
            begin
                pos = 64'(vis) * 42785;
                neg = 64'(ir) * 19548;
                raw = (pos > neg) ? pos - neg : 64'd0;
            end
            else if (ratio < HIGH_BAND_END)
                raw = 64'(vis) * 5926 + 64'(ir) * 1185;
            else
                raw = 0;
            divisor = gain_x(gcode) * (64'(itime_code) + 1) * 50;
            raw = raw / divisor;
            cap = cap_for(range_code);
            if (raw > cap)
                raw = cap;
            if (raw == 0)
                raw = 1;
            return raw[LUX_W-1:0];
        endfunction

        function void note_config(logic [alc_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data);
            case (idx)
                alc_pkg::REG_LUX_RANGE:
                begin
                    range_code      = data[2:0];
                    discard_pending = 1'b1;
                end
                alc_pkg::REG_EXPOSURE:
                begin
                    itime_code      = data[2:0];
                    discard_pending = 1'b1;
                end
                default: ;
            endcase
        endfunction

        function void note_poll(poll_t item);
            logic [7:0]  status;
            logic [15:0] vis;
            logic [15:0] ir;
            status = item[7:0];
            vis    = item[23:8];
            ir     = item[39:24];
            if (!status[alc_pkg::ST_NEW_BIT])
                return;
            if (status[alc_pkg::ST_INVALID_BIT])
                pending_lux.push_back('0);
            else if (discard_pending)
                discard_pending = 1'b0;
            else
                pending_lux.push_back(lux_of(vis, ir, status[alc_pkg::ST_GAIN_LSB +: 3]));
        endfunction

        task check_lux(logic [alc_pkg::OUT_TDATA_W-1:0] beat);
            logic [LUX_W-1:0] want;
            if (pending_lux.size() == 0)
            begin
                report($sformatf("lux_centi %0d with nothing expected", beat[LUX_W-1:0]));
                return;
            end
            want = pending_lux.pop_front();
            if (beat[LUX_W-1:0] !== want)
                report($sformatf("lux_centi %0d, expected %0d", beat[LUX_W-1:0], want));
            if (beat[alc_pkg::OUT_TDATA_W-1:LUX_W] !== '0)
                report($sformatf("pad bits of m_tdata not zero: %h", beat));
        endtask
    endclass

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [alc_pkg::IN_TDATA_W-1:0]     s_tdata;
    logic                               m_tvalid;
    logic                               m_tready;
    logic [alc_pkg::OUT_TDATA_W-1:0]    m_tdata;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [alc_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [alc_pkg::CFG_DATA_W-1:0]     cfg_data;

    lux_predictor lux_pred;
    int           send_idle_pct = 7;
    int           recv_idle_pct = 45;
    int           hold_cycles   = 0;
    int           quiet_cycles  = 0;

    ambient_light_lux_calc_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic poll_t make_poll(bit fresh, bit bad, gain_code_e gain,
                                        logic [15:0] vis, logic [15:0] ir);
        logic [7:0] status;
        status = 8'($urandom);
        status[alc_pkg::ST_NEW_BIT]        = fresh;
        status[alc_pkg::ST_INVALID_BIT]    = bad;
        status[alc_pkg::ST_GAIN_LSB +: 3]  = gain;
        return {ir, vis, status};
    endfunction

    function automatic poll_t random_poll();
        logic [15:0]     vis;
        logic [15:0]     ir;
        longint unsigned scaled;
        int unsigned     ratio_lo;
        int unsigned     ratio_hi;
        case ($urandom_range(5))
            0:
            begin
                vis = 16'($urandom);
                ir  = 16'($urandom);
            end
            5:
            begin
                vis = $urandom_range(1) ? 16'hFFFF : 16'($urandom_range(3));
                ir  = $urandom_range(1) ? 16'hFFFF : 16'($urandom_range(3));
            end
            default:
            begin
                // aim ir/vis (in thousandths) at one segment band
                case ($urandom_range(3))
                    0:
                    begin
                        ratio_lo = 0;
                        ratio_hi = 817;
                    end
                    1:
                    begin
                        ratio_lo = 819;
                        ratio_hi = 1777;
                    end
                    2:
                    begin
                        ratio_lo = 1779;
                        ratio_hi = 5666;
                    end
                    default:
                    begin
                        ratio_lo = 5668;
                        ratio_hi = 60000;
                    end
                endcase
                vis    = 16'($urandom) >> $urandom_range(15);
                scaled = 64'(vis) * $urandom_range(ratio_hi, ratio_lo) / 1000;
                ir     = (scaled > 65535) ? 16'hFFFF : 16'(scaled);
            end
        endcase
        return make_poll($urandom_range(99) < 88, $urandom_range(99) < 8,
                         gain_code_e'($urandom_range(7)), vis, ir);
    endfunction

    // Entered and left at a falling edge.
    task automatic send_poll(poll_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        do
            @(posedge clk);
        while (!s_tready);
        lux_pred.note_poll(item);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [alc_pkg::CFG_IDX_W-1:0] idx, logic [2:0] code);
        logic [7:0] data;
        data      = {5'($urandom), code};
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        lux_pred.note_config(idx, data);
        @(negedge clk);
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (lux_pred.pending() != 0);
    endtask

    // Drain, then give a dropped poll time to leave the pipeline.
    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            lux_pred.check_lux(m_tdata);
        if (rst_n && !((s_tvalid && s_tready) || (m_tvalid && m_tready)
                       || (cfg_valid && cfg_ready)))
            quiet_cycles <= quiet_cycles + 1;
        else
            quiet_cycles <= 0;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("ambient_light_lux_calc_top verification failed");
        $finish;
    end

    initial
    begin
        int         real_phases;
        logic [2:0] next_range;
        logic [2:0] next_itime;
        lux_pred  = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // no new data, then the first valid reading gets dropped, then invalid
        send_poll(make_poll(1'b0, 1'b0, GAIN_1, 16'd1234, 16'd99));
        send_poll(make_poll(1'b1, 1'b0, GAIN_1, 16'd1000, 16'd100));
        send_poll(make_poll(1'b1, 1'b1, GAIN_96, 16'hFFFF, 16'hFFFF));
        // zero count sum, full-scale counts, each segment
        send_poll(make_poll(1'b1, 1'b0, GAIN_1, 16'd0, 16'd0));
        send_poll(make_poll(1'b1, 1'b0, GAIN_1, 16'hFFFF, 16'd0));
        send_poll(make_poll(1'b1, 1'b0, GAIN_1, 16'hFFFF, 16'hFFFF));
        send_poll(make_poll(1'b1, 1'b0, GAIN_1, 16'd0, 16'hFFFF));
        send_poll(make_poll(1'b1, 1'b0, GAIN_1, 16'd10000, 16'd30000));
        for (int g = 0; g < 8; g++)
            send_poll(make_poll(1'b1, 1'b0, gain_code_e'(g), 16'd40000, 16'd5000));
        send_poll({16'd7, 16'd9, 8'hFF});
        send_poll({16'd300, 16'd500, 8'hFB});
        // ratio just below and exactly on each band edge
        send_poll(make_poll(1'b1, 1'b0, GAIN_1, 16'd551, 16'd449));
        send_poll(make_poll(1'b1, 1'b0, GAIN_1, 16'd550, 16'd450));
        send_poll(make_poll(1'b1, 1'b0, GAIN_1, 16'd361, 16'd639));
        send_poll(make_poll(1'b1, 1'b0, GAIN_1, 16'd360, 16'd640));
        send_poll(make_poll(1'b1, 1'b0, GAIN_1, 16'd151, 16'd849));
        send_poll(make_poll(1'b1, 1'b0, GAIN_1, 16'd150, 16'd850));
        settle();

        real_phases = 0;
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == PHASES / 3)
            begin
                send_idle_pct = 45;
                recv_idle_pct = 7;
            end
            else if (p == 2 * PHASES / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (p % 5 == 4)
                write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, 3'($urandom));
            else
            begin
                // walk every code of both registers first, then pick at random
                next_range = (real_phases < 8) ? 3'(real_phases * 5) : 3'($urandom);
                next_itime = (real_phases < 8) ? 3'(real_phases * 3) : 3'($urandom);
                if ($urandom_range(1))
                begin
                    write_reg(alc_pkg::REG_LUX_RANGE, next_range);
                    write_reg(alc_pkg::REG_EXPOSURE, next_itime);
                end
                else
                begin
                    write_reg(alc_pkg::REG_EXPOSURE, next_itime);
                    write_reg(alc_pkg::REG_LUX_RANGE, next_range);
                end
                real_phases++;
            end
            cfg_valid <= 1'b0;

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // stall the output long enough to back up the input
                if ((p == 2 && i == 20) || (p == 12 && i == 30))
                    hold_cycles = HOLD_OFF_CYCLES;
                if ((p == 7 && i == 40) || (p == 13 && i == 10))
                    wait_results();
                send_poll(random_poll());
            end
            settle();
        end

        if (lux_pred.pending() != 0)
            lux_pred.report($sformatf("%0d lux results never arrived", lux_pred.pending()));
        if (lux_pred.errors == 0)
            $display("ambient_light_lux_calc_top verification clean");
        else
            $display("ambient_light_lux_calc_top verification failed");
        $finish;
    end

endmodule
